// ----- rtl/core/binary_min_heap_queue_defines.svh -----
// Assertion macros for the binary min-heap queue checker.
// Standalone header; the calling scope provides i_clk and i_rst_n.
`ifndef BINARY_MIN_HEAP_QUEUE_DEFINES_SVH
`define BINARY_MIN_HEAP_QUEUE_DEFINES_SVH

// Check that cons holds in the same cycle as ante.
`define BMHQ_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check that cons holds in the cycle after ante.
`define BMHQ_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/core/bmhq_pkg.sv -----
// Shared types and codes for the binary min-heap queue.
// No dependencies.
`default_nettype none

package bmhq_pkg;

    localparam logic OP_PUSH = 1'b0;
    localparam logic OP_POP  = 1'b1;

    typedef struct packed {
        logic               operation;
        logic signed [31:0] push_value;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] popped_value;
        logic               was_empty;
        logic               was_full;
        logic        [4:0]  entry_count;
    } t_out_item;

    typedef struct packed {
        logic push;
        logic pop;
    } t_cell_ctrl;

endpackage

`default_nettype wire

// ----- rtl/core/bmhq_cell.sv -----
// One slot of the sorted chain: holds one value and a valid flag.
// Depends on bmhq_pkg for the control struct.
`default_nettype none

module bmhq_cell import bmhq_pkg::*; #(
    parameter int VALUE_BITS = 32
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  t_cell_ctrl                   i_ctrl,
    input  wire signed [VALUE_BITS-1:0]  i_push_value,
    input  wire                          i_left_valid,
    input  wire signed [VALUE_BITS-1:0]  i_left_value,
    input  wire                          i_right_valid,
    input  wire signed [VALUE_BITS-1:0]  i_right_value,
    output logic                         o_valid,
    output logic signed [VALUE_BITS-1:0] o_value
);

    logic                         r_valid;
    logic signed [VALUE_BITS-1:0] r_value;
    logic                         n_valid;
    logic signed [VALUE_BITS-1:0] n_value;
    logic                         w_mine_gt;
    logic                         w_left_gt;

    assign w_mine_gt = !r_valid || (r_value > i_push_value);
    assign w_left_gt = i_left_valid && (i_left_value > i_push_value);

    always_comb begin
        n_valid = r_valid;
        n_value = r_value;
        priority if (i_ctrl.pop) begin
            n_valid = i_right_valid;
            n_value = i_right_value;
        end else if (i_ctrl.push && w_mine_gt) begin
            priority if (w_left_gt) begin
                n_valid = 1'b1;
                n_value = i_left_value;
            end else if (i_left_valid) begin
                n_valid = 1'b1;
                n_value = i_push_value;
            end else begin
                n_valid = r_valid;
                n_value = r_value;
            end
        end else begin
            n_valid = r_valid;
            n_value = r_value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
        r_value <= n_value;
    end

    assign o_valid = r_valid;
    assign o_value = r_value;

endmodule

`default_nettype wire

// ----- rtl/core/binary_min_heap_queue.sv -----
// Min-priority queue built as a sorted chain of compare-and-shift cells.
// Result: registered in the cycle after an item is accepted.
// Throughput: one item per cycle unless stalled; every cell works in that cycle.
// Reset: clears the count, the cell valid flags and the output valid flag.
// Depends on bmhq_pkg and bmhq_cell.
`default_nettype none

module binary_min_heap_queue import bmhq_pkg::*; #(
    parameter int CAPACITY   = 16,
    parameter int VALUE_BITS = 32
) (
    input  wire       i_clk,
    input  wire       i_rst_n,
    input  wire       i_in_valid,
    output logic      o_in_stall,
    input  t_in_item  i_in_item,
    output logic      o_out_valid,
    input  wire       i_out_stall,
    output t_out_item o_out_item
);

    localparam int CountBits = $clog2(CAPACITY + 1);
    localparam logic signed [VALUE_BITS-1:0] MinValue = {1'b1, {(VALUE_BITS-1){1'b0}}};

    logic                         w_cell_valid [CAPACITY];
    logic signed [VALUE_BITS-1:0] w_cell_value [CAPACITY];
    logic signed [VALUE_BITS-1:0] w_push_value;
    t_cell_ctrl                   w_ctrl;
    logic                         w_accept;
    logic                         w_full;
    logic                         w_empty;
    logic                         w_is_pop;

    logic [CountBits-1:0]         r_count;
    logic [CountBits-1:0]         n_count;
    logic                         r_out_valid;
    t_out_item                    r_out_item;
    t_out_item                    n_out_item;

    assign o_in_stall   = r_out_valid && i_out_stall;
    assign w_accept     = i_in_valid && !o_in_stall;
    assign w_full       = (r_count == CountBits'(CAPACITY));
    assign w_empty      = (r_count == '0);
    assign w_is_pop     = (i_in_item.operation == OP_POP);
    assign w_push_value = VALUE_BITS'(i_in_item.push_value);

    assign w_ctrl = t_cell_ctrl'{
        push: w_accept && !w_is_pop && !w_full,
        pop:  w_accept && w_is_pop && !w_empty
    };

    genvar gi;
    generate
        for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
            logic                         w_left_valid;
            logic signed [VALUE_BITS-1:0] w_left_value;
            logic                         w_right_valid;
            logic signed [VALUE_BITS-1:0] w_right_value;

            if (gi == 0) begin : g_head
                assign w_left_valid = 1'b1;
                assign w_left_value = MinValue;
            end else begin : g_body
                assign w_left_valid = w_cell_valid[gi-1];
                assign w_left_value = w_cell_value[gi-1];
            end

            if (gi == CAPACITY - 1) begin : g_tail
                assign w_right_valid = 1'b0;
                assign w_right_value = '0;
            end else begin : g_link
                assign w_right_valid = w_cell_valid[gi+1];
                assign w_right_value = w_cell_value[gi+1];
            end

            bmhq_cell #(
                .VALUE_BITS(VALUE_BITS)
            ) u_cell (
                .i_clk        (i_clk),
                .i_rst_n      (i_rst_n),
                .i_ctrl       (w_ctrl),
                .i_push_value (w_push_value),
                .i_left_valid (w_left_valid),
                .i_left_value (w_left_value),
                .i_right_valid(w_right_valid),
                .i_right_value(w_right_value),
                .o_valid      (w_cell_valid[gi]),
                .o_value      (w_cell_value[gi])
            );
        end
    endgenerate

    always_comb begin
        n_count = r_count;
        priority if (w_ctrl.push) begin
            n_count = r_count + 1'b1;
        end else if (w_ctrl.pop) begin
            n_count = r_count - 1'b1;
        end else begin
            n_count = r_count;
        end
    end

    always_comb begin
        n_out_item.popped_value = w_ctrl.pop ? 32'(w_cell_value[0]) : 32'sd0;
        n_out_item.was_empty    = w_accept && w_is_pop && w_empty;
        n_out_item.was_full     = w_accept && !w_is_pop && w_full;
        n_out_item.entry_count  = 5'(n_count);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_count <= n_count;
            if (w_accept) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
        if (w_accept) begin
            r_out_item <= n_out_item;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule

`default_nettype wire

// ----- rtl/core/bmhq_checker.sv -----
// Port-level checks for the binary min-heap queue, bound to the top level.
// Depends on bmhq_pkg and binary_min_heap_queue_defines.svh.
`default_nettype none
`include "binary_min_heap_queue_defines.svh"

module bmhq_checker import bmhq_pkg::*; #(
    parameter int CAPACITY = 16
) (
    input wire       i_clk,
    input wire       i_rst_n,
    input wire       i_in_valid,
    input wire       o_in_stall,
    input t_in_item  i_in_item,
    input wire       o_out_valid,
    input wire       i_out_stall,
    input t_out_item o_out_item
);

    localparam logic [4:0] FullCount = 5'(CAPACITY);

    logic       w_held;
    logic       w_pop_taken;
    logic       w_out_full;
    logic       w_empty_res;
    logic       w_full_res;
    logic       w_val_zero;
    logic [4:0] w_count;

    assign w_held      = o_out_valid && i_out_stall;
    assign w_pop_taken = i_in_valid && !o_in_stall && (i_in_item.operation == OP_POP);
    assign w_out_full  = o_out_item.was_full;
    assign w_empty_res = o_out_valid && o_out_item.was_empty;
    assign w_full_res  = o_out_valid && w_out_full;
    assign w_val_zero  = (o_out_item.popped_value == 32'sd0);
    assign w_count     = o_out_item.entry_count;

    `BMHQ_ASSERT_NEXT(a_out_hold, w_held, o_out_valid && $stable(o_out_item), "item changed")
    `BMHQ_ASSERT_SAME(a_flags_excl, w_empty_res, !w_out_full, "both flags set")
    `BMHQ_ASSERT_SAME(a_empty_pop, w_empty_res, w_val_zero && w_count == '0, "bad empty pop")
    `BMHQ_ASSERT_SAME(a_full_push, w_full_res, w_val_zero && w_count == FullCount, "bad drop")
    `BMHQ_ASSERT_NEXT(a_pop_kind, w_pop_taken, o_out_valid && !w_out_full, "pop flagged full")

endmodule

bind binary_min_heap_queue bmhq_checker #(
    .CAPACITY(CAPACITY)
) u_bmhq_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_in_valid (i_in_valid),
    .o_in_stall (o_in_stall),
    .i_in_item  (i_in_item),
    .o_out_valid(o_out_valid),
    .i_out_stall(i_out_stall),
    .o_out_item (o_out_item)
);

`default_nettype wire

// ----- test/binary_min_heap_queue_test.sv -----
// Self-checking test of the binary min-heap priority queue: pushes and pops with
// random idling on both channels, checked against a heap kept in a scoreboard class.
// Depends on bmhq_pkg and the binary_min_heap_queue RTL.

module binary_min_heap_queue_test;
    import bmhq_pkg::*;

    localparam int CAPACITY      = 16;
    localparam int RANDOM_ITEMS  = 1924;
    localparam int STALL_LIMIT   = 2000;
    localparam int DRAIN_CYCLES  = 8;

    class heap_mirror;
        logic signed [31:0] heap_entries [CAPACITY];
        int                 fill;
        int                 peak_fill;
        t_out_item          pending_outcomes [$];
        int                 mismatches;
        int                 outcomes_seen;
        int                 pushes;
        int                 pops;
        int                 full_drops;
        int                 empty_pops;

        function new();
            fill = 0;
            peak_fill = 0;
            mismatches = 0;
            outcomes_seen = 0;
            pushes = 0;
            pops = 0;
            full_drops = 0;
            empty_pops = 0;
        endfunction

        function void swap_entries(int a, int b);
            logic signed [31:0] tmp;
            tmp = heap_entries[a];
            heap_entries[a] = heap_entries[b];
            heap_entries[b] = tmp;
        endfunction

        function void apply_operation(t_in_item it);
            t_out_item res;
            int        pos;
            int        up;
            int        left;
            int        pick;
            bit        done;
            res = '0;
            if (it.operation == OP_PUSH) begin
                pushes++;
                if (fill >= CAPACITY) begin
                    res.was_full = 1'b1;
                    full_drops++;
                end else begin
                    heap_entries[fill] = it.push_value;
                    pos = fill;
                    fill++;
                    done = 0;
                    while (pos > 0 && !done) begin
                        up = (pos - 1) / 2;
                        if (heap_entries[pos] < heap_entries[up]) begin
                            swap_entries(pos, up);
                            pos = up;
                        end else begin
                            done = 1;
                        end
                    end
                end
            end else begin
                pops++;
                if (fill == 0) begin
                    res.was_empty = 1'b1;
                    empty_pops++;
                end else begin
                    res.popped_value = heap_entries[0];
                    fill--;
                    heap_entries[0] = heap_entries[fill];
                    pos = 0;
                    done = 0;
                    while (!done) begin
                        left = 2 * pos + 1;
                        if (left >= fill) begin
                            done = 1;
                        end else begin
                            pick = left;
                            if (left + 1 < fill && heap_entries[left + 1] < heap_entries[left])
                                pick = left + 1;
                            if (heap_entries[pick] < heap_entries[pos]) begin
                                swap_entries(pick, pos);
                                pos = pick;
                            end else begin
                                done = 1;
                            end
                        end
                    end
                end
            end
            if (fill > peak_fill)
                peak_fill = fill;
            res.entry_count = 5'(fill);
            pending_outcomes.push_back(res);
        endfunction

        task flag_mismatch(string field, longint got, longint want);
            mismatches++;
            $display("ERROR: result %0d: %s is %0d, expected %0d",
                     outcomes_seen, field, got, want);
        endtask

        task compare_outcome(t_out_item got);
            t_out_item want;
            outcomes_seen++;
            if (pending_outcomes.size() == 0) begin
                flag_mismatch("unexpected result, popped_value", got.popped_value, 0);
            end else begin
                want = pending_outcomes.pop_front();
                if (got.popped_value !== want.popped_value)
                    flag_mismatch("popped_value", got.popped_value, want.popped_value);
                if (got.was_empty !== want.was_empty)
                    flag_mismatch("was_empty", got.was_empty, want.was_empty);
                if (got.was_full !== want.was_full)
                    flag_mismatch("was_full", got.was_full, want.was_full);
                if (got.entry_count !== want.entry_count)
                    flag_mismatch("entry_count", got.entry_count, want.entry_count);
            end
        endtask
    endclass

    logic      i_clk = 1'b0;
    logic      i_rst_n;
    logic      i_in_valid;
    logic      o_in_stall;
    t_in_item  i_in_item;
    logic      o_out_valid;
    logic      i_out_stall;
    t_out_item o_out_item;

    heap_mirror mirror;
    int         send_idle_pct;
    int         recv_idle_pct;
    int         quiet_cycles;

    binary_min_heap_queue dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    always @(negedge i_clk) begin
        i_out_stall <= (recv_idle_pct > 0) && ($urandom_range(99) < recv_idle_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall)
            mirror.compare_outcome(o_out_item);
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("Timeout: no item moved for %0d cycles", STALL_LIMIT);
                $display("Mismatches found");
                $finish;
            end
        end
    end

    // Call at a falling edge; returns at the falling edge after acceptance.
    task send_item(t_in_item it);
        while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_item  <= it;
        @(posedge i_clk);
        while (o_in_stall)
            @(posedge i_clk);
        mirror.apply_operation(it);
        @(negedge i_clk);
    endtask

    task send_push(logic signed [31:0] value);
        t_in_item it;
        it.operation  = OP_PUSH;
        it.push_value = value;
        send_item(it);
    endtask

    task send_pop();
        t_in_item it;
        it.operation  = OP_POP;
        it.push_value = 32'($urandom);
        send_item(it);
    endtask

    function logic signed [31:0] pick_value();
        logic signed [31:0] v;
        case ($urandom_range(9))
            0, 1, 2, 3: v = $signed(32'($urandom_range(16))) - 32'sd8;
            4: begin
                case ($urandom_range(3))
                    0:       v = 32'sh7FFF_FFFF;
                    1:       v = 32'sh8000_0000;
                    2:       v = 32'sd0;
                    default: v = -32'sd1;
                endcase
            end
            default: v = $signed(32'($urandom));
        endcase
        return v;
    endfunction

    task send_random_block(int count);
        int push_pct;
        for (int i = 0; i < count; i++) begin
            if (i % 32 == 0) begin
                case ($urandom_range(4))
                    0:       push_pct = 10;
                    1:       push_pct = 30;
                    2:       push_pct = 50;
                    3:       push_pct = 70;
                    default: push_pct = 90;
                endcase
            end
            if ($urandom_range(99) < push_pct)
                send_push(pick_value());
            else
                send_pop();
        end
    endtask

    initial begin
        mirror = new();
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_in_item = '0;
        send_idle_pct = 23;
        recv_idle_pct = 63;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        send_pop();
        send_push(32'sh7FFF_FFFF);
        send_push(32'sh8000_0000);
        send_push(32'sd0);
        send_push(-32'sd1);
        send_push(32'sd5);
        send_push(32'sd5);
        send_push(-32'sd5);
        send_push(32'sd1);
        send_pop();
        send_pop();
        for (int i = 0; i < 10; i++)
            send_push(pick_value());
        send_push(32'sh7FFF_FFFF);
        send_push(32'sh8000_0000);
        send_pop();
        send_pop();
        send_pop();

        send_random_block(RANDOM_ITEMS / 3);
        send_idle_pct = 63;
        recv_idle_pct = 23;
        send_random_block(RANDOM_ITEMS / 3);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        send_random_block(RANDOM_ITEMS - 2 * (RANDOM_ITEMS / 3));
        i_in_valid <= 1'b0;

        while (mirror.pending_outcomes.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Covered %0d pushes (%0d dropped on a full queue), %0d pops (%0d on empty)",
                 mirror.pushes, mirror.full_drops, mirror.pops, mirror.empty_pops);
        $display("Checked %0d results, peak occupancy %0d of %0d",
                 mirror.outcomes_seen, mirror.peak_fill, CAPACITY);
        if (mirror.mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end
endmodule
